### hw/rtl/vpl_pkg.sv
// Shared types, constants and ROM builder functions for the voice pitch/level block.
`default_nettype none

package vpl_pkg;

    localparam int NOTE_DEPTH   = 129;
    localparam int CENT_DEPTH   = 101;
    localparam int KEY_MAX      = 127;
    localparam int CENTS_SEMI   = 100;
    localparam int RECIP_SHIFT  = 19;
    localparam logic [12:0] RECIP_100 = 13'd5243;

    localparam logic [63:0] FREQ_SCALE = 64'd10000000000;
    localparam logic [63:0] LN2_Q64    = 64'hB17217F7D1CF79AB;

    // notes 69..80 in units of 1e-10 Hz
    localparam logic [63:0] BASE_FREQ [0:11] = '{
        64'd4400000000000, 64'd4661637623206, 64'd4938833029565, 64'd5232511333034,
        64'd5543652657710, 64'd5873295408851, 64'd6222539738712, 64'd6592551217699,
        64'd6984564724849, 64'd7399888568880, 64'd7839908854595, 64'd8306094108883
    };

    typedef logic signed [13:0] cents_t;
    typedef logic [6:0] key_t;
    typedef logic [31:0] note_rom_t [0:NOTE_DEPTH-1];
    typedef logic [16:0] cent_rom_t [0:CENT_DEPTH-1];

    typedef struct packed {
        logic [6:0]  voice;
        logic [14:0] ctrl;
        key_t        key;
        cents_t      tot0;
        cents_t      tot1;
    } front_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid;
        al  = {32'b0, a[31:0]};
        ah  = {32'b0, a[63:32]};
        bl  = {32'b0, b[31:0]};
        bh  = {32'b0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + {32'b0, lh[31:0]} + {32'b0, hl[31:0]};
        return hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    endfunction

    function automatic logic [63:0] div_small(input logic [63:0] x, input int n);
        logic [63:0] res;
        case (n)
            2:       res = x / 2;
            3:       res = x / 3;
            4:       res = x / 4;
            5:       res = x / 5;
            6:       res = x / 6;
            7:       res = x / 7;
            8:       res = x / 8;
            9:       res = x / 9;
            10:      res = x / 10;
            default: res = x;
        endcase
        return res;
    endfunction

    // 65536 / 2^(i/1200), exponent rounded to single precision
    function automatic logic [16:0] cent_entry(input int i);
        logic [63:0] num, m, rem, x63, term, sum, res;
        int k;
        logic done;
        k    = 0;
        done = 1'b0;
        if (i == 0)
        begin
            return 17'd65536;
        end
        for (int j = 0; j < 40; j++)
        begin
            if (!done)
            begin
                num = 64'(i) << k;
                if ((num / 1200) < (64'd1 << 23))
                    k = k + 1;
                else
                    done = 1'b1;
            end
        end
        num = 64'(i) << k;
        m   = num / 1200;
        rem = num % 1200;
        if ((rem * 2 > 1200) || ((rem * 2 == 1200) && m[0]))
            m = m + 1;
        x63  = (mul_hi(m << 40, LN2_Q64) >> (k - 24)) >> 1;
        sum  = 64'd1 << 63;
        term = 64'd1 << 63;
        for (int n = 1; n <= 10; n++)
        begin
            term = div_small(mul_hi(term, x63) << 1, n);
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        res = ((sum >> 46) + 1) >> 1;
        return res[16:0];
    endfunction

    function automatic cent_rom_t build_cent_rom();
        cent_rom_t rom;
        for (int i = 0; i < CENT_DEPTH; i++)
        begin
            rom[i] = cent_entry(i);
        end
        return rom;
    endfunction

    // round(freq * 2^sh / den) by restoring long division, freq < den
    function automatic logic [31:0] scaled_round(input logic [63:0] freq, input int sh,
                                                 input logic [63:0] den);
        logic [63:0] q, r;
        q = '0;
        r = freq;
        for (int s = 0; s < 64; s++)
        begin
            if (s < sh)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
        end
        if (r >= den - r)
            q = q + 1;
        return q[31:0];
    endfunction

    function automatic note_rom_t build_note_rom(input int unsigned clock_hz);
        note_rom_t rom;
        logic [63:0] den;
        int t;
        den = 64'(clock_hz) * FREQ_SCALE;
        for (int i = 0; i < NOTE_DEPTH; i++)
        begin
            t      = i + 3;
            rom[i] = scaled_round(BASE_FREQ[t % 12], 26 + t / 12, den);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/vpl_front.sv
// Front stage: bend to cents, per-oscillator total cents and the level control word.
`default_nettype none

module vpl_front (
    input  wire logic               clk,
    input  wire vpl_pkg::stage_en_t en,
    input  wire logic [6:0]         voice_index,
    input  wire logic [6:0]         note,
    input  wire logic [6:0]         velocity,
    input  wire logic [7:0]         env_level,
    input  wire logic               osc0_enable,
    input  wire logic               osc1_enable,
    input  wire logic signed [6:0]  osc0_detune_semis,
    input  wire logic signed [7:0]  osc0_detune_fine,
    input  wire logic signed [6:0]  osc1_detune_semis,
    input  wire logic signed [7:0]  osc1_detune_fine,
    input  wire logic signed [13:0] pitch_bend,
    output vpl_pkg::front_t         front
);
    import vpl_pkg::*;

    logic signed [21:0] bend_prod;
    logic signed [21:0] bend_adj;
    cents_t             bend_cents;
    cents_t             semi0;
    cents_t             semi1;
    logic [14:0]        lvl_prod;
    front_t             front_reg;
    front_t             front_next;

    always_comb
    begin
        bend_prod  = 22'(pitch_bend) * 22'sd200;
        // truncate toward zero
        bend_adj   = bend_prod + (bend_prod[21] ? 22'sd8191 : 22'sd0);
        bend_cents = 14'(bend_adj >>> 13);
        semi0      = 14'(osc0_detune_semis) * 14'sd100;
        semi1      = 14'(osc1_detune_semis) * 14'sd100;
        lvl_prod   = 15'(velocity) * 15'(env_level);

        front_next.voice = voice_index;
        front_next.ctrl  = {lvl_prod[14:8], 6'b0, osc1_enable, osc0_enable};
        front_next.key   = note;
        front_next.tot0  = bend_cents + semi0 + 14'(osc0_detune_fine);
        front_next.tot1  = bend_cents + semi1 + 14'(osc1_detune_fine);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

### hw/rtl/vpl_lane.sv
// One oscillator lane: cents normalization, key saturation, ROM lookup and scaling.
`default_nettype none

module vpl_lane #(
    parameter int unsigned CLOCK_HZ = 50000000
) (
    input  wire logic               clk,
    input  wire vpl_pkg::stage_en_t en,
    input  wire vpl_pkg::key_t      key,
    input  wire vpl_pkg::cents_t    tot,
    output logic [31:0]             inc
);
    import vpl_pkg::*;

    localparam note_rom_t NOTE_ROM = build_note_rom(CLOCK_HZ);
    localparam cent_rom_t CENT_ROM = build_cent_rom();

    // stage 2
    logic [12:0] mag_next, mag_reg;
    logic [25:0] quo_prod;
    logic [6:0]  quo_reg;
    logic        neg_reg, big_reg;
    key_t        key_reg;
    cents_t      neg_tot;

    // stage 3
    logic [12:0]       hund;
    logic [6:0]        rem;
    logic signed [8:0] key_sum;
    logic [6:0]        key_sat;
    logic [7:0]        note_idx_next, note_idx_reg;
    logic [6:0]        cent_idx_next, cent_idx_reg;

    // stage 4/5
    logic [31:0] note_val_reg;
    logic [16:0] cent_val_reg;
    logic [48:0] prod;
    logic [31:0] inc_reg;

    always_comb
    begin
        neg_tot  = -tot;
        mag_next = tot[13] ? neg_tot[12:0] : tot[12:0];
        quo_prod = 26'(mag_next) * 26'(RECIP_100);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            mag_reg <= mag_next;
            quo_reg <= quo_prod[RECIP_SHIFT +: 7];
            neg_reg <= tot[13];
            big_reg <= !tot[13] && (tot > 14'(CENTS_SEMI));
            key_reg <= key;
        end
    end

    always_comb
    begin
        hund = 13'(quo_reg) * 13'(CENTS_SEMI);
        rem  = 7'(mag_reg - hund);
        if (neg_reg)
        begin
            key_sum       = 9'(key_reg) - 9'(quo_reg) - 9'sd1;
            cent_idx_next = rem;
        end
        else if (big_reg)
        begin
            key_sum       = 9'(key_reg) + 9'(quo_reg);
            cent_idx_next = 7'(CENTS_SEMI) - rem;
        end
        else
        begin
            key_sum       = 9'(key_reg);
            cent_idx_next = 7'(CENTS_SEMI) - mag_reg[6:0];
        end
        if (key_sum < 0)
            key_sat = '0;
        else if (key_sum > 9'(KEY_MAX))
            key_sat = 7'(KEY_MAX);
        else
            key_sat = key_sum[6:0];
        note_idx_next = 8'(key_sat) + 8'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            note_idx_reg <= note_idx_next;
            cent_idx_reg <= cent_idx_next;
        end
        if (en.s4)
        begin
            note_val_reg <= NOTE_ROM[note_idx_reg];
            cent_val_reg <= CENT_ROM[cent_idx_reg];
        end
        if (en.s5)
        begin
            inc_reg <= prod[47:16];
        end
    end

    assign prod = 49'(note_val_reg) * 49'(cent_val_reg);
    assign inc  = inc_reg;

endmodule

`default_nettype wire

### hw/rtl/voice_pitch_level_compute.sv
// Top level: pipeline control, front stage, two oscillator lanes and result register.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  request | req_valid/req_ready + voice data | in
//  result  | rsp_valid/rsp_ready + incr/ctrl  | out
//
// Five-stage pipeline: front, divide-by-100, normalize/saturate, ROM read, scale.
// One request per cycle sustained while rsp_ready is high; the scale stage holds otherwise.
// Reset clears only the stage valid bits; ROMs are constants built at elaboration.
// Each stage holds only when it is full and the one after it is stalled, so bubbles collapse.
`default_nettype none

module voice_pitch_level_compute #(
    parameter int unsigned CLOCK_HZ = 50000000
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [6:0]         voice_index,
    input  wire logic [6:0]         note,
    input  wire logic [6:0]         velocity,
    input  wire logic [7:0]         env_level,
    input  wire logic               osc0_enable,
    input  wire logic               osc1_enable,
    input  wire logic signed [6:0]  osc0_detune_semis,
    input  wire logic signed [7:0]  osc0_detune_fine,
    input  wire logic signed [6:0]  osc1_detune_semis,
    input  wire logic signed [7:0]  osc1_detune_fine,
    input  wire logic signed [13:0] pitch_bend,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic [6:0]              voice_id,
    output logic [14:0]             ctrl_word,
    output logic [31:0]             osc0_increment,
    output logic [31:0]             osc1_increment
);
    import vpl_pkg::*;

    stage_en_t   en;
    logic [4:0]  vld_reg;
    logic [4:0]  vld_next;
    front_t      front;
    logic [6:0]  vid_reg   [2:5];
    logic [14:0] ctrl_reg  [2:5];

    always_comb
    begin
        en.s5 = !vld_reg[4] || rsp_ready;
        en.s4 = !vld_reg[3] || en.s5;
        en.s3 = !vld_reg[2] || en.s4;
        en.s2 = !vld_reg[1] || en.s3;
        en.s1 = !vld_reg[0] || en.s2;
        vld_next[0] = en.s1 ? req_valid  : vld_reg[0];
        vld_next[1] = en.s2 ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en.s3 ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en.s4 ? vld_reg[2] : vld_reg[3];
        vld_next[4] = en.s5 ? vld_reg[3] : vld_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            vid_reg[2]  <= front.voice;
            ctrl_reg[2] <= front.ctrl;
        end
        if (en.s3)
        begin
            vid_reg[3]  <= vid_reg[2];
            ctrl_reg[3] <= ctrl_reg[2];
        end
        if (en.s4)
        begin
            vid_reg[4]  <= vid_reg[3];
            ctrl_reg[4] <= ctrl_reg[3];
        end
        if (en.s5)
        begin
            vid_reg[5]  <= vid_reg[4];
            ctrl_reg[5] <= ctrl_reg[4];
        end
    end

    vpl_front u_front (
        .clk               (clk),
        .en                (en),
        .voice_index       (voice_index),
        .note              (note),
        .velocity          (velocity),
        .env_level         (env_level),
        .osc0_enable       (osc0_enable),
        .osc1_enable       (osc1_enable),
        .osc0_detune_semis (osc0_detune_semis),
        .osc0_detune_fine  (osc0_detune_fine),
        .osc1_detune_semis (osc1_detune_semis),
        .osc1_detune_fine  (osc1_detune_fine),
        .pitch_bend        (pitch_bend),
        .front             (front)
    );

    vpl_lane #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_lane0 (
        .clk (clk),
        .en  (en),
        .key (front.key),
        .tot (front.tot0),
        .inc (osc0_increment)
    );

    vpl_lane #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_lane1 (
        .clk (clk),
        .en  (en),
        .key (front.key),
        .tot (front.tot1),
        .inc (osc1_increment)
    );

    assign req_ready = en.s1;
    assign rsp_valid = vld_reg[4];
    assign voice_id  = vid_reg[5];
    assign ctrl_word = ctrl_reg[5];

endmodule

`default_nettype wire
